/* rtl/per_minute_event_count_history_defines.svh */
// Assertion macros shared by the per-minute event count history RTL.
`ifndef PER_MINUTE_EVENT_COUNT_HISTORY_DEFINES_SVH
`define PER_MINUTE_EVENT_COUNT_HISTORY_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define PMECH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PMECH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pmech_pkg.sv */
// Types and constants shared by the per-minute event count history block.
package pmech_pkg;

   localparam int SLOTS   = 64;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int FILL_W  = $clog2(SLOTS + 1);
   localparam int COUNT_W = 16;
   localparam int TOTAL_W = 32;
   localparam int SAMPLE_W = 64;
   localparam int AGE_W   = 6;
   localparam int CMD_W   = 3;

   localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

   typedef struct packed {
      logic               clear;
      logic               wr_en;
      logic [SLOT_W-1:0]  wr_addr;
      logic [COUNT_W-1:0] wr_data;
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_events;
      logic [COUNT_W-1:0] current_minute_count;
      logic [FILL_W-1:0]  elapsed_minutes;
      logic [COUNT_W-1:0] history_value;
      logic               history_valid;
      logic [COUNT_W-1:0] peak_minute;
      logic [FILL_W-1:0]  active_minutes;
      logic               events_seen;
      logic               minute_advanced;
   } result_type;

endpackage

/* rtl/pmech_slot_mem.sv */
// Ring of per-minute slot counts: one write port, one registered read port.
module pmech_slot_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  pmech_pkg::mem_req_type      mem_req,
   output logic [pmech_pkg::COUNT_W-1:0] rd_data
);
   import pmech_pkg::*;

   logic [COUNT_W-1:0] slot_mem_ff [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [COUNT_W-1:0] data_ff;
   logic               hit_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         data_ff <= slot_mem_ff[mem_req.rd_addr];
      end
   end

   // An entry that was never written since the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (mem_req.clear) begin
            valid_ff <= '0;
         end else if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            hit_ff <= valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

/* rtl/pmech_ctrl.sv */
// Command sequencer: sample accumulation, ring advance and the query scan.
`include "per_minute_event_count_history_defines.svh"

module pmech_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pmech_pkg::CMD_W-1:0]    req_cmd,
   input  logic [pmech_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [pmech_pkg::AGE_W-1:0]    req_history_age,
   input  logic                           out_ready,
   output logic                           res_valid,
   output pmech_pkg::result_type          res,
   output pmech_pkg::mem_req_type         mem_req,
   input  logic [pmech_pkg::COUNT_W-1:0]  rd_data
);
   import pmech_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SAMP, ST_QRY, ST_RESP} state_type;

   state_type           state_ff;
   logic                running_ff;
   logic [SLOT_W-1:0]   cur_ff;
   logic [FILL_W-1:0]   filled_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [SAMPLE_W-1:0] last_ff;
   logic [COUNT_W-1:0]  cur_count_ff;
   logic [SAMPLE_W-1:0] delta_ff;
   logic [AGE_W-1:0]    age_ff;
   logic [FILL_W-1:0]   iss_ff;
   logic                pend_ff;
   logic [SLOT_W-1:0]   pidx_ff;
   logic [COUNT_W-1:0]  hval_ff;
   logic                hvalid_ff;
   logic [COUNT_W-1:0]  peak_ff;
   logic [FILL_W-1:0]   active_ff;
   logic                seen_ff;
   logic                adv_ff;

   logic                accept;
   logic [SAMPLE_W:0]   diff;
   logic                counts_up;
   logic [TOTAL_W:0]    tot_sum;
   logic                tot_sat;
   logic [TOTAL_W-1:0]  tot_in;
   logic [COUNT_W:0]    slot_sum;
   logic                slot_sat;
   logic [COUNT_W-1:0]  slot_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // A delta counts only against a nonzero baseline and a rising counter.
   assign diff      = {1'b0, req_sample} - {1'b0, last_ff};
   assign counts_up = !diff[SAMPLE_W] && (|diff[SAMPLE_W-1:0]) && (|last_ff);

   assign tot_sum  = {1'b0, total_ff} + {1'b0, delta_ff[TOTAL_W-1:0]};
   assign tot_sat  = (|delta_ff[SAMPLE_W-1:TOTAL_W]) || tot_sum[TOTAL_W]
                     || (&tot_sum[TOTAL_W-1:0]);
   assign tot_in   = tot_sat ? '1 : tot_sum[TOTAL_W-1:0];

   assign slot_sum = {1'b0, rd_data} + {1'b0, delta_ff[COUNT_W-1:0]};
   assign slot_sat = (|delta_ff[SAMPLE_W-1:COUNT_W]) || slot_sum[COUNT_W]
                     || (&slot_sum[COUNT_W-1:0]);
   assign slot_in  = slot_sat ? '1 : slot_sum[COUNT_W-1:0];

   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_START: begin
                     mem_req.clear = !running_ff;
                  end
                  CMD_SAMPLE: begin
                     mem_req.rd_en   = running_ff && counts_up;
                     mem_req.rd_addr = cur_ff;
                  end
                  CMD_TICK: begin
                     mem_req.wr_en   = running_ff;
                     mem_req.wr_addr = cur_ff + 1'b1;
                     mem_req.wr_data = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SAMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_data = slot_in;
         end
         ST_QRY: begin
            mem_req.rd_en   = (iss_ff < filled_ff);
            mem_req.rd_addr = cur_ff - iss_ff[SLOT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         cur_ff       <= '0;
         filled_ff    <= '0;
         total_ff     <= '0;
         last_ff      <= '0;
         cur_count_ff <= '0;
         delta_ff     <= '0;
         age_ff       <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         pidx_ff      <= '0;
         hval_ff      <= '0;
         hvalid_ff    <= 1'b0;
         peak_ff      <= '0;
         active_ff    <= '0;
         seen_ff      <= 1'b0;
         adv_ff       <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  hval_ff   <= '0;
                  hvalid_ff <= (req_cmd == CMD_QUERY)
                               && (FILL_W'(req_history_age) < filled_ff);
                  peak_ff   <= '0;
                  active_ff <= '0;
                  seen_ff   <= (req_cmd == CMD_SAMPLE) && running_ff && counts_up;
                  adv_ff    <= (req_cmd == CMD_TICK) && running_ff;
                  case (req_cmd)
                     CMD_START: begin
                        state_ff <= ST_RESP;
                        if (!running_ff) begin
                           running_ff   <= 1'b1;
                           cur_ff       <= '0;
                           filled_ff    <= '0;
                           total_ff     <= '0;
                           cur_count_ff <= '0;
                           last_ff      <= req_sample;
                        end
                     end
                     CMD_SAMPLE: begin
                        state_ff <= (running_ff && counts_up) ? ST_SAMP : ST_RESP;
                        if (running_ff) begin
                           last_ff <= req_sample;
                           if (counts_up) begin
                              delta_ff <= diff[SAMPLE_W-1:0];
                           end
                        end
                     end
                     CMD_TICK: begin
                        state_ff <= ST_RESP;
                        if (running_ff) begin
                           cur_ff       <= cur_ff + 1'b1;
                           cur_count_ff <= '0;
                           if (filled_ff != FILL_W'(SLOTS)) begin
                              filled_ff <= filled_ff + 1'b1;
                           end
                        end
                     end
                     CMD_QUERY: begin
                        age_ff    <= req_history_age;
                        iss_ff    <= '0;
                        pend_ff   <= 1'b0;
                        state_ff  <= ST_QRY;
                     end
                     CMD_STOP: begin
                        running_ff <= 1'b0;
                        state_ff   <= ST_RESP;
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_SAMP: begin
               total_ff     <= tot_in;
               cur_count_ff <= slot_in;
               state_ff     <= ST_RESP;
            end
            ST_QRY: begin
               if (pend_ff) begin
                  if (rd_data > peak_ff) begin
                     peak_ff <= rd_data;
                  end
                  if (rd_data != '0) begin
                     active_ff <= active_ff + 1'b1;
                  end
                  if (FILL_W'(pidx_ff) == FILL_W'(age_ff)) begin
                     hval_ff <= rd_data;
                  end
               end
               if (iss_ff < filled_ff) begin
                  iss_ff  <= iss_ff + 1'b1;
                  pend_ff <= 1'b1;
                  pidx_ff <= iss_ff[SLOT_W-1:0];
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_RESP: begin
               if (out_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign res_valid = (state_ff == ST_RESP) && out_ready;

   always_comb begin
      res.total_events         = total_ff;
      res.current_minute_count = (filled_ff != '0) ? cur_count_ff : '0;
      res.elapsed_minutes      = filled_ff;
      res.history_value        = hval_ff;
      res.history_valid        = hvalid_ff;
      res.peak_minute          = peak_ff;
      res.active_minutes       = active_ff;
      res.events_seen          = seen_ff;
      res.minute_advanced      = adv_ff;
   end

   `PMECH_ASSERT_SAME(a_no_rw_clash, clock, reset, mem_req.wr_en, !mem_req.rd_en,
      "Slot memory read and written in the same cycle.")
   `PMECH_ASSERT_NEXT(a_tick_advances, clock, reset,
      accept && (req_cmd == CMD_TICK) && running_ff,
      cur_ff == SLOT_W'($past(cur_ff) + 1'b1), "Tick did not advance the ring.")
   `PMECH_ASSERT_SAME(a_active_bound, clock, reset, state_ff == ST_QRY,
      active_ff <= iss_ff, "Active count exceeds the slots read.")
   `PMECH_ASSERT_NEXT(a_start_clears, clock, reset,
      accept && (req_cmd == CMD_START) && !running_ff,
      (filled_ff == '0) && (total_ff == '0) && running_ff, "Start did not clear the state.")

endmodule

/* rtl/per_minute_event_count_history.sv */
// Top level of the per-minute event count history block.
//
// The req_ channel carries one command word: start, counter sample, minute
// tick, query or stop, with the raw 64-bit counter value and a history age.
// Every accepted word gives exactly one rsp_ word with the running total,
// the current minute count, the elapsed minutes and, for a query, the slot
// at the requested age, the peak minute and the number of active minutes.
// A word is taken only while the sequencer is idle. Start, tick, stop and
// ignored commands go straight to the response state, a counting sample
// first reads its slot and writes it back, and a query scans the slot
// memory over the elapsed minutes, one entry per cycle.
// The response sits in an output register, so a new word is accepted while
// the previous response is still waiting for rsp_ready; if that response is
// still not taken when the next one is finished, the sequencer holds.
// Reset empties the ring at once through per-slot valid bits, stops the
// block and drops any response not yet taken.
module per_minute_event_count_history (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pmech_pkg::CMD_W-1:0]    req_cmd,
   input  logic [pmech_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [pmech_pkg::AGE_W-1:0]    req_history_age,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pmech_pkg::TOTAL_W-1:0]  rsp_total_events,
   output logic [pmech_pkg::COUNT_W-1:0]  rsp_current_minute_count,
   output logic [pmech_pkg::FILL_W-1:0]   rsp_elapsed_minutes,
   output logic [pmech_pkg::COUNT_W-1:0]  rsp_history_value,
   output logic                           rsp_history_valid,
   output logic [pmech_pkg::COUNT_W-1:0]  rsp_peak_minute,
   output logic [pmech_pkg::FILL_W-1:0]   rsp_active_minutes,
   output logic                           rsp_events_seen,
   output logic                           rsp_minute_advanced
);
   import pmech_pkg::*;

   mem_req_type        mem_req;
   logic [COUNT_W-1:0] rd_data;
   logic               out_ready;
   logic               res_valid;
   result_type         res;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   assign out_ready = !rsp_valid_ff || rsp_ready;

   pmech_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   pmech_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_sample      (req_sample),
      .req_history_age (req_history_age),
      .out_ready       (out_ready),
      .res_valid       (res_valid),
      .res             (res),
      .mem_req         (mem_req),
      .rd_data         (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_total_events         = rsp_ff.total_events;
   assign rsp_current_minute_count = rsp_ff.current_minute_count;
   assign rsp_elapsed_minutes      = rsp_ff.elapsed_minutes;
   assign rsp_history_value        = rsp_ff.history_value;
   assign rsp_history_valid        = rsp_ff.history_valid;
   assign rsp_peak_minute          = rsp_ff.peak_minute;
   assign rsp_active_minutes       = rsp_ff.active_minutes;
   assign rsp_events_seen          = rsp_ff.events_seen;
   assign rsp_minute_advanced      = rsp_ff.minute_advanced;

endmodule

/* bench/per_minute_event_count_history_test.sv */
// Self-checking testbench for the per-minute event count history block.
module per_minute_event_count_history_test;
   import pmech_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam int ITEM_TARGET    = 1800;
   localparam int DRAIN_CYCLES   = 80;
   localparam int HOLD_CYCLES    = 600;
   localparam int TIMEOUT_CYCLES = 1_500_000;

   class minute_history_board;
      logic [COUNT_W-1:0]  slot_count [SLOTS];
      logic [SLOT_W-1:0]   head_slot;
      logic [FILL_W-1:0]   filled;
      logic [TOTAL_W-1:0]  total;
      logic [SAMPLE_W-1:0] baseline;
      logic                counting;
      result_type          pending_results [$];
      int                  fails;

      function new();
         foreach (slot_count[i]) slot_count[i] = '0;
         head_slot = '0;
         filled    = '0;
         total     = '0;
         baseline  = '0;
         counting  = 1'b0;
         fails     = 0;
      endfunction

      function void note_word(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                              logic [AGE_W-1:0] age);
         result_type          r;
         logic [SLOT_W-1:0]   addr;
         logic [SAMPLE_W-1:0] delta;
         r = '0;
         case (cmd)
            CMD_START: begin
               if (!counting) begin
                  counting = 1'b1;
                  foreach (slot_count[i]) slot_count[i] = '0;
                  head_slot = '0;
                  filled    = '0;
                  total     = '0;
                  baseline  = smp;
               end
            end
            CMD_SAMPLE: begin
               if (counting) begin
                  if (baseline != '0 && smp > baseline) begin
                     delta = smp - baseline;
                     if (delta >= {{(SAMPLE_W-TOTAL_W){1'b0}}, ~total})
                        total = '1;
                     else
                        total = total + delta[TOTAL_W-1:0];
                     if (delta >= {{(SAMPLE_W-COUNT_W){1'b0}}, ~slot_count[head_slot]})
                        slot_count[head_slot] = '1;
                     else
                        slot_count[head_slot] = slot_count[head_slot] + delta[COUNT_W-1:0];
                     r.events_seen = 1'b1;
                  end
                  baseline = smp;
               end
            end
            CMD_TICK: begin
               if (counting) begin
                  head_slot = head_slot + 1'b1;
                  slot_count[head_slot] = '0;
                  if (filled < SLOTS)
                     filled = filled + 1'b1;
                  r.minute_advanced = 1'b1;
               end
            end
            CMD_QUERY: begin
               if (age < filled) begin
                  addr = head_slot - age;
                  r.history_valid = 1'b1;
                  r.history_value = slot_count[addr];
               end
               for (int i = 0; i < filled; i++) begin
                  addr = head_slot - SLOT_W'(i);
                  if (slot_count[addr] > r.peak_minute)
                     r.peak_minute = slot_count[addr];
                  if (slot_count[addr] != '0)
                     r.active_minutes = r.active_minutes + 1'b1;
               end
            end
            CMD_STOP: counting = 1'b0;
            default: ;
         endcase
         r.total_events         = total;
         r.current_minute_count = (filled != '0) ? slot_count[head_slot] : '0;
         r.elapsed_minutes      = filled;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            fails++;
            if (fails <= 10)
               $display("Mismatch in %s: expected %0h, got %0h", name, want, got);
         end
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            fails++;
            if (fails <= 10)
               $display("Response word arrived with none outstanding");
            return;
         end
         want = pending_results.pop_front();
         compare_field("total_events", want.total_events, got.total_events);
         compare_field("current_minute_count", want.current_minute_count,
                       got.current_minute_count);
         compare_field("elapsed_minutes", want.elapsed_minutes, got.elapsed_minutes);
         compare_field("history_value", want.history_value, got.history_value);
         compare_field("history_valid", want.history_valid, got.history_valid);
         compare_field("peak_minute", want.peak_minute, got.peak_minute);
         compare_field("active_minutes", want.active_minutes, got.active_minutes);
         compare_field("events_seen", want.events_seen, got.events_seen);
         compare_field("minute_advanced", want.minute_advanced, got.minute_advanced);
      endfunction

      function void close_out();
         if (pending_results.size() != 0) begin
            fails += pending_results.size();
            $display("%0d response words never arrived", pending_results.size());
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [SAMPLE_W-1:0] req_sample;
   logic [AGE_W-1:0]    req_history_age;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [TOTAL_W-1:0]  rsp_total_events;
   logic [COUNT_W-1:0]  rsp_current_minute_count;
   logic [FILL_W-1:0]   rsp_elapsed_minutes;
   logic [COUNT_W-1:0]  rsp_history_value;
   logic                rsp_history_valid;
   logic [COUNT_W-1:0]  rsp_peak_minute;
   logic [FILL_W-1:0]   rsp_active_minutes;
   logic                rsp_events_seen;
   logic                rsp_minute_advanced;

   minute_history_board board = new();
   int                  send_idle_pct = 7;
   int                  recv_idle_pct = 72;
   int                  sent_items = 0;
   bit                  hold_request = 1'b0;

   per_minute_event_count_history u_top (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_cmd                  (req_cmd),
      .req_sample               (req_sample),
      .req_history_age          (req_history_age),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_total_events         (rsp_total_events),
      .rsp_current_minute_count (rsp_current_minute_count),
      .rsp_elapsed_minutes      (rsp_elapsed_minutes),
      .rsp_history_value        (rsp_history_value),
      .rsp_history_valid        (rsp_history_valid),
      .rsp_peak_minute          (rsp_peak_minute),
      .rsp_active_minutes       (rsp_active_minutes),
      .rsp_events_seen          (rsp_events_seen),
      .rsp_minute_advanced      (rsp_minute_advanced)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp,
                            input logic [AGE_W-1:0] age);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_sample      <= smp;
      req_history_age <= age;
      do @(posedge clock); while (!req_ready);
      board.note_word(cmd, smp, age);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_results.size() != 0);
   endtask

   task automatic run_segment();
      int                  len;
      int                  pick;
      int                  extra;
      logic [SAMPLE_W-1:0] ctr;
      pick = $urandom_range(0, 99);
      len  = (pick < 30) ? $urandom_range(250, 400) : $urandom_range(10, 120);
      if (len > ITEM_TARGET - sent_items)
         len = ITEM_TARGET - sent_items;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         ctr = '0;
      else if (pick < 20)
         ctr = {$urandom, $urandom};
      else
         ctr = SAMPLE_W'($urandom_range(1, 1_000_000));
      send_word(CMD_START, ctr, AGE_W'($urandom));
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 46) begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
               ctr = ctr + $urandom_range(1, 300);
            else if (pick < 68)
               ctr = ctr;
            else if (pick < 76)
               ctr = ctr - $urandom_range(1, 1000);
            else if (pick < 87)
               ctr = ctr + $urandom_range(65536, 1 << 20);
            else if (pick < 90)
               ctr = ctr + $urandom;
            else if (pick < 95)
               ctr = {$urandom, $urandom};
            else
               ctr = '0;
            send_word(CMD_SAMPLE, ctr, AGE_W'($urandom));
         end else if (pick < 70) begin
            send_word(CMD_TICK, {$urandom, $urandom}, AGE_W'($urandom));
         end else if (pick < 95) begin
            send_word(CMD_QUERY, {$urandom, $urandom}, AGE_W'($urandom));
         end else if (pick < 98) begin
            send_word(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                      {$urandom, $urandom}, AGE_W'($urandom));
         end else begin
            send_word(CMD_START, {$urandom, $urandom}, AGE_W'($urandom));
         end
      end
      send_word(CMD_STOP, {$urandom, $urandom}, AGE_W'($urandom));
      extra = $urandom_range(0, 3);
      repeat (extra)
         send_word(CMD_W'($urandom_range(CMD_SAMPLE, CMD_SPARE_HI)), {$urandom, $urandom},
                   AGE_W'($urandom));
      sent_items += len + 2 + extra;
   endtask

   initial begin
      int         hold_left;
      result_type got;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_total_events, rsp_current_minute_count, rsp_elapsed_minutes,
                   rsp_history_value, rsp_history_valid, rsp_peak_minute,
                   rsp_active_minutes, rsp_events_seen, rsp_minute_advanced};
            board.check_word(got);
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_START;
      req_sample      <= '0;
      req_history_age <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The first three words below are issued against a block that has not been started.
      send_word(CMD_QUERY, '0, '0);
      send_word(CMD_SAMPLE, 64'd5, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_START, '0, '0);
      send_word(CMD_SAMPLE, 64'd100, '0);
      send_word(CMD_SAMPLE, 64'd150, '0);
      send_word(CMD_SAMPLE, 64'd150, '0);
      send_word(CMD_SAMPLE, 64'd120, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      send_word(CMD_QUERY, '0, '0);
      send_word(CMD_QUERY, '0, '1);
      send_word(CMD_START, 64'd7, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_SAMPLE, '0, '0);
      send_word(CMD_SAMPLE, 64'd10, '0);
      send_word(CMD_SAMPLE, 64'd70010, '0);
      send_word(CMD_QUERY, '0, 6'd1);
      send_word(CMD_STOP, '0, '0);
      send_word(CMD_STOP, '0, '0);
      send_word(CMD_SAMPLE, 64'd99999, '0);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_QUERY, '0, 6'd1);
      send_word(CMD_SPARE_LO, '1, '1);
      send_word(CMD_SPARE_HI, '0, '0);
      wait_drained();

      hold_request = 1'b1;
      while (sent_items < ITEM_TARGET) begin
         if (sent_items >= 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent_items >= ITEM_TARGET / 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 7;
         end
         run_segment();
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.close_out();
      if (board.fails == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #(20 * TIMEOUT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pmech_pkg.sv
rtl/pmech_slot_mem.sv
rtl/pmech_ctrl.sv
rtl/per_minute_event_count_history.sv
bench/per_minute_event_count_history_test.sv
